@@ design/mept_pkg.sv @@
package mept_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_CHANNEL_ENABLE  = 2'd0;
  localparam logic [1:0] CFG_RUN_ENABLE      = 2'd1;
  localparam logic [1:0] CFG_TICKS_PER_CM    = 2'd2;
  localparam logic [1:0] CFG_MAX_RANGE_TICKS = 2'd3;

  // Fixed field widths
  localparam int LEVEL_W = 8;
  localparam int TPC_W   = 16;
  localparam int RANGE_W = 24;
  localparam int PULSE_W = 24;
  localparam int DIST_W  = 16;
  localparam int CHAN_W  = 4;

  localparam logic [TPC_W-1:0]   TPC_RESET   = 16'd928;
  localparam logic [RANGE_W-1:0] RANGE_RESET = 24'd371200;
  localparam logic [DIST_W-1:0]  DIST_MAX    = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } mept_state_t;

endpackage

@@ design/mept_div.sv @@
module mept_div
  import mept_pkg::*;
#(
  parameter int TIME_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [TIME_BITS-1:0] dividend,
  input  logic [TPC_W-1:0]     divisor,
  output logic                 done,
  output logic [DIST_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(TIME_BITS + 1);

  logic [TIME_BITS-1:0] q_r;
  logic [TPC_W-1:0]     rem_r;
  logic [TPC_W-1:0]     dvs_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [TPC_W:0]       trial;
  logic                 fits;

  // One restoring step per cycle; a zero divisor gives all ones, which saturates
  assign trial = {rem_r, q_r[TIME_BITS-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(TIME_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= TPC_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_r <= trial[TPC_W-1:0];
      end
      q_r <= {q_r[TIME_BITS-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = ((q_r >> DIST_W) != '0) ? DIST_MAX : q_r[DIST_W-1:0];

endmodule

@@ design/multichannel_echo_pulse_timer_top.sv @@
// Multichannel echo pulse timer.
// Input stream: one beat per sampling tick, in_tdata holds the echo levels
// of the channels (bit n is channel n+1). Configuration: plain write port,
// index 0 channel enable, 1 run enable, 2 ticks per cm, 3 max range ticks.
// Output stream: one beat per falling edge on an enabled channel, channels
// in ascending order; out_tlast marks the final beat caused by one input.
// Per input beat: an accept step, then a scan of each channel in turn
// (up to 8), plus a divide for each falling edge by the bit-serial
// divider that turns pulse ticks into centimeters. With run enable low
// a beat is taken and dropped, and time does not advance. A result
// goes from the divider through the emit state to the output register.
// Reset clears the tick counter, previous levels, start times and config
// to their defaults; no clearing pass is needed. A result waits in the
// output register while the receiver stalls; scanning holds only when a
// second result is ready before the first is taken.
module multichannel_echo_pulse_timer_top
  import mept_pkg::*;
#(
  parameter int CHANNELS  = 8,
  parameter int TIME_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] echo_levels
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [3:0] channel, [27:4] pulse_ticks,
                                  // [43:28] distance_cm, [44] over_range
  output logic        out_tlast,  // last
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  // Only the channels carried on the input can ever see an edge
  localparam int LANES = (CHANNELS < LEVEL_W) ? CHANNELS : LEVEL_W;
  localparam int CH_W  = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int CMP_W = (TIME_BITS > RANGE_W) ? TIME_BITS : RANGE_W;
  localparam logic [CH_W-1:0]    LAST_CH   = CH_W'(LANES - 1);
  localparam logic [LEVEL_W-1:0] LANE_MASK = LEVEL_W'((9'd1 << LANES) - 9'd1);

  // Configuration
  logic [LEVEL_W-1:0] chan_en_r;
  logic               run_r;
  logic [TPC_W-1:0]   tpc_r;
  logic [RANGE_W-1:0] max_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_en_r   <= '0;
      run_r       <= 1'b0;
      tpc_r       <= TPC_RESET;
      max_range_r <= RANGE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHANNEL_ENABLE:  chan_en_r   <= cfg_wdata[LEVEL_W-1:0];
        CFG_RUN_ENABLE:      run_r       <= cfg_wdata[0];
        CFG_TICKS_PER_CM:    tpc_r       <= cfg_wdata[TPC_W-1:0];
        CFG_MAX_RANGE_TICKS: max_range_r <= cfg_wdata[RANGE_W-1:0];
        default:             run_r       <= run_r;
      endcase
    end
  end

  // Sequencer state
  mept_state_t          state_r, state_nxt;
  logic [CH_W-1:0]      ch_r, ch_nxt;
  logic [LEVEL_W-1:0]   levels_r, levels_nxt;
  logic [LEVEL_W-1:0]   prev_r, prev_nxt;
  logic [LEVEL_W-1:0]   act_r, act_nxt;
  logic [LEVEL_W-1:0]   fall_r, fall_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic [TIME_BITS-1:0] item_time_r, item_time_nxt;
  logic [TIME_BITS-1:0] ticks_r, ticks_nxt;

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  logic [CHAN_W-1:0]    o_chan_r, o_chan_nxt;
  logic [PULSE_W-1:0]   o_pulse_r, o_pulse_nxt;
  logic [DIST_W-1:0]    o_dist_r, o_dist_nxt;
  logic                 o_over_r, o_over_nxt;
  logic                 o_last_r, o_last_nxt;

  // Start time store, one entry per lane
  logic [TIME_BITS-1:0] start_mem_r [LANES];
  logic [TIME_BITS-1:0] start_rd;
  logic                 start_we;

  logic                 div_start;
  logic                 div_done;
  logic [DIST_W-1:0]    div_q;
  logic [LEVEL_W-1:0]   ch_onehot;

  assign start_rd  = start_mem_r[ch_r];
  assign ch_onehot = LEVEL_W'(1) << ch_r;
  assign in_tready = (state_r == ST_IDLE);

  mept_div #(
    .TIME_BITS (TIME_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ticks_nxt),
    .divisor  (tpc_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    levels_nxt    = levels_r;
    prev_nxt      = prev_r;
    act_nxt       = act_r;
    fall_nxt      = fall_r;
    time_nxt      = time_r;
    item_time_nxt = item_time_r;
    ticks_nxt     = ticks_r;
    out_valid_nxt = out_valid_r;
    o_chan_nxt    = o_chan_r;
    o_pulse_nxt   = o_pulse_r;
    o_dist_nxt    = o_dist_r;
    o_over_nxt    = o_over_r;
    o_last_nxt    = o_last_r;
    start_we      = 1'b0;
    div_start     = 1'b0;

    // Drop the held beat once the receiver takes it
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && run_r) begin
          levels_nxt    = in_tdata;
          act_nxt       = chan_en_r & (in_tdata ^ prev_r) & LANE_MASK;
          fall_nxt      = chan_en_r & (in_tdata ^ prev_r) & LANE_MASK & ~in_tdata;
          prev_nxt      = in_tdata;
          item_time_nxt = time_r;
          time_nxt      = time_r + TIME_BITS'(1);
          ch_nxt        = '0;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (act_r[ch_r] && !levels_r[ch_r]) begin
          // Falling edge: hand the pulse length to the divider
          ticks_nxt = item_time_r - start_rd;
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          // Rising edge stores the start time; otherwise skip the lane
          start_we = act_r[ch_r];
          if (ch_r == LAST_CH) begin
            state_nxt = ST_IDLE;
          end else begin
            ch_nxt = ch_r + CH_W'(1);
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          o_chan_nxt    = CHAN_W'(ch_r) + CHAN_W'(1);
          o_pulse_nxt   = PULSE_W'(ticks_r);
          o_dist_nxt    = div_q;
          o_over_nxt    = CMP_W'(ticks_r) > CMP_W'(max_range_r);
          o_last_nxt    = (fall_r & ~ch_onehot) == '0;
          fall_nxt      = fall_r & ~ch_onehot;
          if (ch_r == LAST_CH) begin
            state_nxt = ST_IDLE;
          end else begin
            ch_nxt    = ch_r + CH_W'(1);
            state_nxt = ST_SCAN;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      time_r      <= '0;
      prev_r      <= '0;
      ch_r        <= '0;
      act_r       <= '0;
      fall_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      time_r      <= time_nxt;
      prev_r      <= prev_nxt;
      ch_r        <= ch_nxt;
      act_r       <= act_nxt;
      fall_r      <= fall_nxt;
    end
  end

  always_ff @(posedge clk) begin
    levels_r    <= levels_nxt;
    item_time_r <= item_time_nxt;
    ticks_r     <= ticks_nxt;
    o_chan_r    <= o_chan_nxt;
    o_pulse_r   <= o_pulse_nxt;
    o_dist_r    <= o_dist_nxt;
    o_over_r    <= o_over_nxt;
    o_last_r    <= o_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANES; i++) begin
        start_mem_r[i] <= '0;
      end
    end else if (start_we) begin
      start_mem_r[ch_r] <= item_time_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {3'b000, o_over_r, o_dist_r, o_pulse_r, o_chan_r};

endmodule
